>>> design/mips_subset_execute_defines.svh
// ----------------------------------------------------------------------------
// mips_subset_execute assertion macros
// shared property wrappers, clocked on i_clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_DEFINES_SVH

// same-cycle implication
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// shared constants, instruction codes and structs of the execute block
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam logic [31:0] TEXT_BASE     = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE     = 32'h1001_0000;
    localparam int          MEM_BYTES_DEF = 8192;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // function codes of the register format
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // reported mnemonics
    localparam logic [4:0] MN_ADD     = 5'd0;
    localparam logic [4:0] MN_ADDU    = 5'd1;
    localparam logic [4:0] MN_SUB     = 5'd2;
    localparam logic [4:0] MN_AND     = 5'd3;
    localparam logic [4:0] MN_OR      = 5'd4;
    localparam logic [4:0] MN_XOR     = 5'd5;
    localparam logic [4:0] MN_SLT     = 5'd6;
    localparam logic [4:0] MN_SRL     = 5'd7;
    localparam logic [4:0] MN_SLL     = 5'd8;
    localparam logic [4:0] MN_JR      = 5'd9;
    localparam logic [4:0] MN_SYSCALL = 5'd10;
    localparam logic [4:0] MN_LW      = 5'd11;
    localparam logic [4:0] MN_SW      = 5'd12;
    localparam logic [4:0] MN_LB      = 5'd13;
    localparam logic [4:0] MN_SB      = 5'd14;
    localparam logic [4:0] MN_LH      = 5'd15;
    localparam logic [4:0] MN_SH      = 5'd16;
    localparam logic [4:0] MN_ADDI    = 5'd17;
    localparam logic [4:0] MN_ADDIU   = 5'd18;
    localparam logic [4:0] MN_ANDI    = 5'd19;
    localparam logic [4:0] MN_ORI     = 5'd20;
    localparam logic [4:0] MN_XORI    = 5'd21;
    localparam logic [4:0] MN_SLTI    = 5'd22;
    localparam logic [4:0] MN_LUI     = 5'd23;
    localparam logic [4:0] MN_BEQ     = 5'd24;
    localparam logic [4:0] MN_BNE     = 5'd25;
    localparam logic [4:0] MN_J       = 5'd26;
    localparam logic [4:0] MN_JAL     = 5'd27;
    localparam logic [4:0] MN_UNKNOWN = 5'd28;

    // access sizes in bytes
    localparam logic [2:0] SZ_BYTE = 3'd1;
    localparam logic [2:0] SZ_HALF = 3'd2;
    localparam logic [2:0] SZ_WORD = 3'd4;

    localparam logic [4:0] LINK_REG = 5'd31;

    // decoded and executed instruction
    typedef struct packed {
        logic [4:0]  mn;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        logic        load;
        logic        store;
        logic [2:0]  size;
        logic [31:0] maddr;
        logic [31:0] tgt;
    } t_exec;

    // data memory request
    typedef struct packed {
        logic        acc;
        logic        store;
        logic [2:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

>>> design/mse_exu.sv
// ----------------------------------------------------------------------------
// mse_exu
// instruction decode, alu, effective address and branch target
// ----------------------------------------------------------------------------
module mse_exu (
    input  logic [31:0]     i_instr,
    input  logic [31:0]     i_pc,
    input  logic [31:0]     i_op_a,
    input  logic [31:0]     i_op_b,
    output mse_pkg::t_exec  o_ex
);
    import mse_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] ea;

    always_comb begin
        op   = i_instr[31:26];
        fn   = i_instr[5:0];
        rt   = i_instr[20:16];
        rd   = i_instr[15:11];
        sh   = i_instr[10:6];
        imm  = {16'h0000, i_instr[15:0]};
        simm = {{16{i_instr[15]}}, i_instr[15:0]};
        pc4  = i_pc + 32'd4;
        ea   = i_op_a + simm;

        o_ex    = '0;
        o_ex.mn = MN_UNKNOWN;

        case (op)
            OP_RTYPE: begin
                case (fn)
                    FN_ADD: begin
                        o_ex.mn = MN_ADD; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a + i_op_b;
                    end
                    FN_ADDU: begin
                        o_ex.mn = MN_ADDU; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a + i_op_b;
                    end
                    FN_SUB: begin
                        o_ex.mn = MN_SUB; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a - i_op_b;
                    end
                    FN_AND: begin
                        o_ex.mn = MN_AND; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a & i_op_b;
                    end
                    FN_OR: begin
                        o_ex.mn = MN_OR; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a | i_op_b;
                    end
                    FN_XOR: begin
                        o_ex.mn = MN_XOR; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_a ^ i_op_b;
                    end
                    FN_SLT: begin
                        o_ex.mn = MN_SLT; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = {31'd0, $signed(i_op_a) < $signed(i_op_b)};
                    end
                    FN_SRL: begin
                        o_ex.mn = MN_SRL; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_b >> sh;
                    end
                    FN_SLL: begin
                        o_ex.mn = MN_SLL; o_ex.wr = 1'b1; o_ex.dst = rd;
                        o_ex.val = i_op_b << sh;
                    end
                    FN_JR: begin
                        o_ex.mn  = MN_JR;
                        o_ex.tgt = i_op_a;
                    end
                    FN_SYSCALL: begin
                        o_ex.mn = MN_SYSCALL;
                    end
                    default: begin
                        o_ex.mn = MN_UNKNOWN;
                    end
                endcase
            end
            OP_J: begin
                o_ex.mn  = MN_J;
                o_ex.tgt = {pc4[31:28], i_instr[25:0], 2'b00};
            end
            OP_JAL: begin
                o_ex.mn  = MN_JAL;
                o_ex.tgt = {pc4[31:28], i_instr[25:0], 2'b00};
                o_ex.wr  = 1'b1;
                o_ex.dst = LINK_REG;
                o_ex.val = pc4;
            end
            OP_LW: begin
                o_ex.mn = MN_LW; o_ex.load = 1'b1; o_ex.dst = rt;
                o_ex.size = SZ_WORD; o_ex.maddr = ea;
            end
            OP_LB: begin
                o_ex.mn = MN_LB; o_ex.load = 1'b1; o_ex.dst = rt;
                o_ex.size = SZ_BYTE; o_ex.maddr = ea;
            end
            OP_LH: begin
                o_ex.mn = MN_LH; o_ex.load = 1'b1; o_ex.dst = rt;
                o_ex.size = SZ_HALF; o_ex.maddr = ea;
            end
            OP_SW: begin
                o_ex.mn = MN_SW; o_ex.store = 1'b1;
                o_ex.size = SZ_WORD; o_ex.maddr = ea;
            end
            OP_SB: begin
                o_ex.mn = MN_SB; o_ex.store = 1'b1;
                o_ex.size = SZ_BYTE; o_ex.maddr = ea;
            end
            OP_SH: begin
                o_ex.mn = MN_SH; o_ex.store = 1'b1;
                o_ex.size = SZ_HALF; o_ex.maddr = ea;
            end
            OP_ADDI: begin
                o_ex.mn = MN_ADDI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = i_op_a + simm;
            end
            OP_ADDIU: begin
                o_ex.mn = MN_ADDIU; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = i_op_a + simm;
            end
            OP_ANDI: begin
                o_ex.mn = MN_ANDI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = i_op_a & imm;
            end
            OP_ORI: begin
                o_ex.mn = MN_ORI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = i_op_a | imm;
            end
            OP_XORI: begin
                o_ex.mn = MN_XORI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = i_op_a ^ imm;
            end
            OP_SLTI: begin
                o_ex.mn = MN_SLTI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = {31'd0, $signed(i_op_a) < $signed(simm)};
            end
            OP_LUI: begin
                o_ex.mn = MN_LUI; o_ex.wr = 1'b1; o_ex.dst = rt;
                o_ex.val = {i_instr[15:0], 16'h0000};
            end
            OP_BEQ: begin
                o_ex.mn  = MN_BEQ;
                o_ex.tgt = pc4 + {simm[29:0], 2'b00};
            end
            OP_BNE: begin
                o_ex.mn  = MN_BNE;
                o_ex.tgt = pc4 + {simm[29:0], 2'b00};
            end
            default: begin
                o_ex.mn = MN_UNKNOWN;
            end
        endcase
    end

endmodule

>>> design/mse_dmem.sv
// ----------------------------------------------------------------------------
// mse_dmem
// byte-lane data memory with window check, unaligned access and clearing pass
// ----------------------------------------------------------------------------
module mse_dmem #(
    parameter int MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  mse_pkg::t_mem_req i_req,
    output logic              o_fault,
    output logic              o_busy,
    output logic [31:0]       o_ld_data
);
    import mse_pkg::*;

    localparam int ROWS  = MEM_BYTES / 4;
    localparam int OFF_W = $clog2(MEM_BYTES);
    localparam int ROW_W = OFF_W - 2;

    logic [31:0]      off;
    logic             in_win;
    logic             wr_ok;
    logic [1:0]       off_lo;
    logic [ROW_W-1:0] row_base;

    logic             r_clr;
    logic [ROW_W-1:0] r_clr_row;

    logic [7:0]       r_rd [4];
    logic [1:0]       r_off_lo;
    logic [2:0]       r_size;
    logic [31:0]      raw;

    always_comb begin
        off      = i_req.addr - DATA_BASE;
        in_win   = ({1'b0, off} + 33'(i_req.size)) <= 33'(MEM_BYTES);
        o_fault  = i_req.acc && !in_win;
        wr_ok    = i_req.acc && i_req.store && in_win;
        off_lo   = off[1:0];
        row_base = off[OFF_W-1:2];
    end

    // clearing pass, one row of every lane per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign o_busy = r_clr;

    for (genvar j = 0; j < 4; j++) begin : g_lane
        localparam logic [1:0] LANE_ID = 2'(j);

        logic [7:0]       mem [ROWS];
        logic [1:0]       byte_sel;
        logic [ROW_W-1:0] row;
        logic             we;
        logic [7:0]       wbyte;

        always_comb begin
            byte_sel = LANE_ID - off_lo;
            row      = row_base + ROW_W'(LANE_ID < off_lo);
            we       = wr_ok && ({1'b0, byte_sel} < i_req.size);
            wbyte    = 8'(i_req.wdata >> {byte_sel, 3'b000});
        end

        always_ff @(posedge i_clk) begin
            if (r_clr) begin
                mem[r_clr_row] <= '0;
            end else if (we) begin
                mem[row] <= wbyte;
            end
            if (i_en) begin
                r_rd[j] <= mem[row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off_lo <= off_lo;
            r_size   <= i_req.size;
        end
    end

    // rotate lanes back into byte order, then sign extend
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            raw[8*i +: 8] = r_rd[2'(r_off_lo + 2'(i))];
        end
        case (r_size)
            SZ_BYTE: o_ld_data = {{24{raw[7]}}, raw[7:0]};
            SZ_HALF: o_ld_data = {{16{raw[15]}}, raw[15:0]};
            default: o_ld_data = raw;
        endcase
    end

endmodule

>>> design/mips_subset_execute.sv
// ----------------------------------------------------------------------------
// mips_subset_execute
// executes one mips instruction word per transfer and reports its effects
// ----------------------------------------------------------------------------
// The block takes one instruction word per cycle while o_stall is low and
// gives one result per instruction, in order, through the register file
// read, execute and memory access, then the output register. A new
// instruction can be taken in every cycle in which o_stall is low;
// dependent instructions need no gaps because results, load data included,
// are forwarded back to the operands. The pipeline moves as a whole and
// holds while a result waits behind a stall on the output. After reset the
// data memory is cleared one row (four bytes) per cycle, over all
// MEM_BYTES/4 rows, during which o_stall is held high. Branches and jumps
// only report their target; the instruction address always advances by
// four. Accesses outside the data window raise fault and change nothing.

`include "mips_subset_execute_defines.svh"

module mips_subset_execute #(
    parameter int MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // instruction channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_instr_addr,
    output logic [4:0]  o_mnemonic,
    output logic        o_reg_write,
    output logic [4:0]  o_dest_reg,
    output logic [31:0] o_write_value,
    output logic        o_mem_read,
    output logic        o_mem_write,
    output logic [31:0] o_mem_addr,
    output logic [31:0] o_target_addr,
    output logic        o_fault
);
    import mse_pkg::*;

    // pipeline control
    logic        en;
    logic        accept;
    logic        dm_busy;
    logic [4:0]  rs_in;
    logic [4:0]  rt_in;

    // instruction address counter
    logic [31:0] r_pc;
    logic [31:0] n_pc;

    // register file, read data registered, valid bit per entry
    logic [31:0] rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] n_rf_vld;
    logic [31:0] r_rfa;
    logic [31:0] r_rfb;
    logic        rf_we;

    // execute stage
    logic        r1_v;
    logic [31:0] r1_instr;
    logic [31:0] r1_pc;
    logic        r1_a_vld;
    logic        r1_b_vld;
    logic        r1_a_byp;
    logic        r1_b_byp;
    logic [31:0] r1_a_bval;
    logic [31:0] r1_b_bval;
    logic [31:0] op_a;
    logic [31:0] op_b;
    t_exec       ex;
    t_mem_req    mreq;
    logic        fault1;
    logic        wr1;

    // memory stage
    logic        r2_v;
    logic [31:0] r2_pc;
    logic [4:0]  r2_mn;
    logic        r2_wr;
    logic [4:0]  r2_dst;
    logic [31:0] r2_val;
    logic        r2_load;
    logic        r2_mwr;
    logic [31:0] r2_maddr;
    logic [31:0] r2_tgt;
    logic        r2_fault;
    logic [31:0] ld_data;
    logic [31:0] s2_val;

    // output register
    logic        r_ov;
    logic [31:0] r_o_pc;
    logic [4:0]  r_o_mn;
    logic        r_o_wr;
    logic [4:0]  r_o_dst;
    logic [31:0] r_o_val;
    logic        r_o_mrd;
    logic        r_o_mwr;
    logic [31:0] r_o_maddr;
    logic [31:0] r_o_tgt;
    logic        r_o_fault;

    // whole pipeline advances unless a result is held by a stall
    assign en      = !(r_ov && i_stall);
    assign o_stall = !en || dm_busy;
    assign accept  = i_valid && !o_stall;
    assign rs_in   = i_instr_word[25:21];
    assign rt_in   = i_instr_word[20:16];

    // instruction address
    always_comb begin
        n_pc = r_pc;
        if (accept) begin
            n_pc = r_pc + 32'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= TEXT_BASE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // register file write back from the memory stage
    assign rf_we = en && r2_v && r2_wr;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[r2_dst] <= s2_val;
        end
        if (en) begin
            r_rfa <= rf[rs_in];
            r_rfb <= rf[rt_in];
        end
    end

    always_comb begin
        n_rf_vld = r_rf_vld;
        if (rf_we) begin
            n_rf_vld[r2_dst] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else begin
            r_rf_vld <= n_rf_vld;
        end
    end

    // input register; catches the write back that coincides with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_instr  <= i_instr_word;
            r1_pc     <= r_pc;
            r1_a_vld  <= r_rf_vld[rs_in];
            r1_b_vld  <= r_rf_vld[rt_in];
            r1_a_byp  <= r2_v && r2_wr && (r2_dst == rs_in);
            r1_b_byp  <= r2_v && r2_wr && (r2_dst == rt_in);
            r1_a_bval <= s2_val;
            r1_b_bval <= s2_val;
        end
    end

    // operand select: previous instruction first, then the captured write
    // back, then the register file; an entry never written reads as zero
    always_comb begin
        if (r2_v && r2_wr && (r2_dst == r1_instr[25:21])) begin
            op_a = s2_val;
        end else if (r1_a_byp) begin
            op_a = r1_a_bval;
        end else if (r1_a_vld) begin
            op_a = r_rfa;
        end else begin
            op_a = '0;
        end
        if (r2_v && r2_wr && (r2_dst == r1_instr[20:16])) begin
            op_b = s2_val;
        end else if (r1_b_byp) begin
            op_b = r1_b_bval;
        end else if (r1_b_vld) begin
            op_b = r_rfb;
        end else begin
            op_b = '0;
        end
    end

    mse_exu u_exu (
        .i_instr (r1_instr),
        .i_pc    (r1_pc),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_ex    (ex)
    );

    always_comb begin
        mreq.acc   = r1_v && (ex.load || ex.store);
        mreq.store = ex.store;
        mreq.size  = ex.size;
        mreq.addr  = ex.maddr;
        mreq.wdata = op_b;
    end

    mse_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_req     (mreq),
        .o_fault   (fault1),
        .o_busy    (dm_busy),
        .o_ld_data (ld_data)
    );

    // register zero is never written, a faulting load writes nothing
    assign wr1 = (ex.wr || (ex.load && !fault1)) && (ex.dst != 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pc    <= r1_pc;
            r2_mn    <= ex.mn;
            r2_wr    <= wr1;
            r2_dst   <= wr1 ? ex.dst : 5'd0;
            r2_val   <= (wr1 && !ex.load) ? ex.val : 32'd0;
            r2_load  <= ex.load;
            r2_mwr   <= ex.store;
            r2_maddr <= ex.maddr;
            r2_tgt   <= ex.tgt;
            r2_fault <= fault1;
        end
    end

    assign s2_val = (r2_load && r2_wr) ? ld_data : r2_val;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pc    <= r2_pc;
            r_o_mn    <= r2_mn;
            r_o_wr    <= r2_wr;
            r_o_dst   <= r2_dst;
            r_o_val   <= s2_val;
            r_o_mrd   <= r2_load;
            r_o_mwr   <= r2_mwr;
            r_o_maddr <= r2_maddr;
            r_o_tgt   <= r2_tgt;
            r_o_fault <= r2_fault;
        end
    end

    assign o_valid       = r_ov;
    assign o_instr_addr  = r_o_pc;
    assign o_mnemonic    = r_o_mn;
    assign o_reg_write   = r_o_wr;
    assign o_dest_reg    = r_o_dst;
    assign o_write_value = r_o_val;
    assign o_mem_read    = r_o_mrd;
    assign o_mem_write   = r_o_mwr;
    assign o_mem_addr    = r_o_maddr;
    assign o_target_addr = r_o_tgt;
    assign o_fault       = r_o_fault;

    // checks
    `MSE_ASSERT_IMP(a_no_zero_write, r2_v && r2_wr, r2_dst != 5'd0, "write to register zero")
    `MSE_ASSERT_IMP(a_fault_no_write, r2_v && r2_fault, !r2_wr, "faulting access wrote")
    `MSE_ASSERT_IMP(a_clear_blocks, dm_busy, o_stall && !r1_v, "transfer during clearing")
    `MSE_ASSERT_NXT(a_hold_on_stall, r_ov && i_stall, $stable(r2_pc) && $stable(r_o_pc), "pipeline moved while held")

endmodule

>>> dv/mse_effect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_effect_checker
// watches both channels of the execute block, runs each instruction word that
// is taken on its own copy of the machine state and compares every reported
// result with the oldest outstanding one
// ----------------------------------------------------------------------------

module mse_effect_checker #(
    parameter int MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // instruction channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_instr_word,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_instr_addr,
    input  logic [4:0]  i_mnemonic,
    input  logic        i_reg_write,
    input  logic [4:0]  i_dest_reg,
    input  logic [31:0] i_write_value,
    input  logic        i_mem_read,
    input  logic        i_mem_write,
    input  logic [31:0] i_mem_addr,
    input  logic [31:0] i_target_addr,
    input  logic        i_fault,
    output int          o_mismatches,
    output int          o_outstanding
);

    import mse_pkg::*;

    typedef struct packed {
        logic [31:0] instr_addr;
        logic [4:0]  mnemonic;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] target_addr;
        logic        fault;
    } t_effect;

    logic [31:0] pc_copy;
    logic [31:0] gpr_copy [32];
    logic [7:0]  dmem_copy [MEM_BYTES];
    t_effect     effect_q [$];
    int          mismatch_count = 0;

    // executes one word on the local machine state and returns its effects
    task automatic run_instruction(input logic [31:0] w, output t_effect e);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] off;
        logic [31:0] ld;
        logic [2:0]  size;
        logic        wr;
        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        sh   = w[10:6];
        fn   = w[5:0];
        imm  = {16'h0000, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        a    = gpr_copy[rs];
        b    = gpr_copy[rt];
        e    = '0;
        e.instr_addr = pc_copy;
        e.mnemonic   = MN_UNKNOWN;
        wr   = 1'b0;
        size = '0;
        if (op == OP_RTYPE) begin
            wr = 1'b1;
            e.dest_reg = rd;
            case (fn)
                FN_ADD:     begin e.mnemonic = MN_ADD;  e.write_value = a + b; end
                FN_ADDU:    begin e.mnemonic = MN_ADDU; e.write_value = a + b; end
                FN_SUB:     begin e.mnemonic = MN_SUB;  e.write_value = a - b; end
                FN_AND:     begin e.mnemonic = MN_AND;  e.write_value = a & b; end
                FN_OR:      begin e.mnemonic = MN_OR;   e.write_value = a | b; end
                FN_XOR:     begin e.mnemonic = MN_XOR;  e.write_value = a ^ b; end
                FN_SLT:     begin
                    e.mnemonic    = MN_SLT;
                    e.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                end
                FN_SRL:     begin e.mnemonic = MN_SRL;  e.write_value = b >> sh; end
                FN_SLL:     begin e.mnemonic = MN_SLL;  e.write_value = b << sh; end
                FN_JR:      begin e.mnemonic = MN_JR; wr = 1'b0; e.target_addr = a; end
                FN_SYSCALL: begin e.mnemonic = MN_SYSCALL; wr = 1'b0; end
                default:    wr = 1'b0;
            endcase
        end else if (op == OP_J || op == OP_JAL) begin
            e.target_addr = {e.instr_addr[31:28] + 4'(e.instr_addr[27:0] > 28'hFFF_FFFB),
                             w[25:0], 2'b00};
            if (op == OP_J) begin
                e.mnemonic = MN_J;
            end else begin
                e.mnemonic    = MN_JAL;
                wr            = 1'b1;
                e.dest_reg    = LINK_REG;
                e.write_value = pc_copy + 32'd4;
            end
        end else begin
            case (op)
                OP_LW:    begin e.mnemonic = MN_LW; e.mem_read  = 1'b1; size = SZ_WORD; end
                OP_LB:    begin e.mnemonic = MN_LB; e.mem_read  = 1'b1; size = SZ_BYTE; end
                OP_LH:    begin e.mnemonic = MN_LH; e.mem_read  = 1'b1; size = SZ_HALF; end
                OP_SW:    begin e.mnemonic = MN_SW; e.mem_write = 1'b1; size = SZ_WORD; end
                OP_SB:    begin e.mnemonic = MN_SB; e.mem_write = 1'b1; size = SZ_BYTE; end
                OP_SH:    begin e.mnemonic = MN_SH; e.mem_write = 1'b1; size = SZ_HALF; end
                OP_ADDI:  begin e.mnemonic = MN_ADDI;  e.write_value = a + simm; end
                OP_ADDIU: begin e.mnemonic = MN_ADDIU; e.write_value = a + simm; end
                OP_ANDI:  begin e.mnemonic = MN_ANDI;  e.write_value = a & imm; end
                OP_ORI:   begin e.mnemonic = MN_ORI;   e.write_value = a | imm; end
                OP_XORI:  begin e.mnemonic = MN_XORI;  e.write_value = a ^ imm; end
                OP_SLTI:  begin
                    e.mnemonic    = MN_SLTI;
                    e.write_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                OP_LUI:   begin e.mnemonic = MN_LUI; e.write_value = imm << 16; end
                OP_BEQ:   begin
                    e.mnemonic    = MN_BEQ;
                    e.target_addr = pc_copy + 32'd4 + (simm << 2);
                end
                OP_BNE:   begin
                    e.mnemonic    = MN_BNE;
                    e.target_addr = pc_copy + 32'd4 + (simm << 2);
                end
                default: ;
            endcase
            // immediate ops all write rt
            if (e.mnemonic >= MN_ADDI && e.mnemonic <= MN_LUI) begin
                wr = 1'b1;
                e.dest_reg = rt;
            end
            if (size != '0) begin
                e.mem_addr = a + simm;
                off = e.mem_addr - DATA_BASE;
                if ((33'(off) + 33'(size)) > 33'(MEM_BYTES)) begin
                    e.fault = 1'b1;
                end else if (e.mem_write) begin
                    for (int i = 0; i < int'(size); i++)
                        dmem_copy[off + i] = b[8*i +: 8];
                end else begin
                    ld = '0;
                    for (int i = 0; i < int'(size); i++)
                        ld[8*i +: 8] = dmem_copy[off + i];
                    if (size == SZ_BYTE)
                        ld = {{24{ld[7]}}, ld[7:0]};
                    else if (size == SZ_HALF)
                        ld = {{16{ld[15]}}, ld[15:0]};
                    wr = 1'b1;
                    e.dest_reg    = rt;
                    e.write_value = ld;
                end
            end
        end
        // register zero never takes a write
        if (wr && e.dest_reg != 5'd0) begin
            e.reg_write = 1'b1;
            gpr_copy[e.dest_reg] = e.write_value;
        end else begin
            e.reg_write   = 1'b0;
            e.dest_reg    = '0;
            e.write_value = '0;
        end
        pc_copy = pc_copy + 32'd4;
    endtask

    function automatic string effect_text(t_effect e);
        return $sformatf("pc=%h mn=%0d rw=%b rd=%0d val=%h ld=%b st=%b ma=%h tgt=%h flt=%b",
                         e.instr_addr, e.mnemonic, e.reg_write, e.dest_reg, e.write_value,
                         e.mem_read, e.mem_write, e.mem_addr, e.target_addr, e.fault);
    endfunction

    always @(posedge i_clk) begin : watch
        t_effect issued;
        t_effect want;
        t_effect got;
        if (!i_rst_n) begin
            pc_copy = TEXT_BASE;
            for (int r = 0; r < 32; r++)
                gpr_copy[r] = '0;
            for (int m = 0; m < MEM_BYTES; m++)
                dmem_copy[m] = '0;
            effect_q.delete();
        end else begin
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                run_instruction(i_instr_word, issued);
                effect_q.push_back(issued);
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = {i_instr_addr, i_mnemonic, i_reg_write, i_dest_reg, i_write_value,
                       i_mem_read, i_mem_write, i_mem_addr, i_target_addr, i_fault};
                if (effect_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result transfer: %s", effect_text(got));
                    mismatch_count++;
                end else begin
                    want = effect_q.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("result mismatch at pc %h", want.instr_addr);
                            $display("  expected %s", effect_text(want));
                            $display("  actual   %s", effect_text(got));
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= effect_q.size();
    end

endmodule

>>> dv/tb_mips_subset_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_subset_execute
// feeds directed and random instruction streams to the execute block in
// random bursts against a stalling result side; a separate checker runs the
// same stream on its own machine state and counts mismatches
// ----------------------------------------------------------------------------

module tb_mips_subset_execute;

    import mse_pkg::*;

    localparam int MEM_BYTES    = MEM_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1500;
    // slack for the drain, well above the depth of the three-stage pipeline
    localparam int DRAIN_CYCLES = 16;
    // memory clearing after reset plus every item at its worst gap and stall
    localparam int CYCLE_LIMIT  = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instr_word;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_instr_addr;
    logic [4:0]  o_mnemonic;
    logic        o_reg_write;
    logic [4:0]  o_dest_reg;
    logic [31:0] o_write_value;
    logic        o_mem_read;
    logic        o_mem_write;
    logic [31:0] o_mem_addr;
    logic [31:0] o_target_addr;
    logic        o_fault;

    int          mismatches;
    int          outstanding;
    int unsigned cycle_count;
    logic [31:0] instr_stream [$];

    mips_subset_execute #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_instr_word  (i_instr_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_instr_addr  (o_instr_addr),
        .o_mnemonic    (o_mnemonic),
        .o_reg_write   (o_reg_write),
        .o_dest_reg    (o_dest_reg),
        .o_write_value (o_write_value),
        .o_mem_read    (o_mem_read),
        .o_mem_write   (o_mem_write),
        .o_mem_addr    (o_mem_addr),
        .o_target_addr (o_target_addr),
        .o_fault       (o_fault)
    );

    mse_effect_checker #(
        .MEM_BYTES(MEM_BYTES)
    ) u_effect_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_instr_word  (i_instr_word),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_instr_addr  (o_instr_addr),
        .i_mnemonic    (o_mnemonic),
        .i_reg_write   (o_reg_write),
        .i_dest_reg    (o_dest_reg),
        .i_write_value (o_write_value),
        .i_mem_read    (o_mem_read),
        .i_mem_write   (o_mem_write),
        .i_mem_addr    (o_mem_addr),
        .i_target_addr (o_target_addr),
        .i_fault       (o_fault),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // instruction encoders
    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] idx);
        return {op, idx};
    endfunction

    // directed opening: $1 points at the start of the data window, then every
    // operation at least once with the edge cases of sign handling, register zero,
    // unaligned accesses and faults on both sides of the window
    task automatic add_directed();
        instr_stream.push_back(enc_i(OP_LUI,   5'd0, 5'd1, DATA_BASE[31:16]));
        instr_stream.push_back(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
        instr_stream.push_back(enc_i(OP_ORI,   5'd0, 5'd3, 16'h8000));
        // write to register zero is dropped
        instr_stream.push_back(enc_i(OP_ADDI,  5'd2, 5'd0, 16'h7FFF));
        instr_stream.push_back(enc_i(OP_SW,    5'd1, 5'd2, 16'h0000));
        // unaligned half store
        instr_stream.push_back(enc_i(OP_SH,    5'd1, 5'd3, 16'h0007));
        // last byte of the window
        instr_stream.push_back(enc_i(OP_SB,    5'd1, 5'd2, 16'(MEM_BYTES - 1)));
        instr_stream.push_back(enc_i(OP_LB,    5'd1, 5'd4, 16'(MEM_BYTES - 1)));
        instr_stream.push_back(enc_i(OP_LH,    5'd1, 5'd5, 16'h0007));
        instr_stream.push_back(enc_i(OP_LW,    5'd1, 5'd6, 16'h0001));
        // word straddling the top of the window, byte just below its bottom
        instr_stream.push_back(enc_i(OP_LW,    5'd1, 5'd7, 16'(MEM_BYTES - 3)));
        instr_stream.push_back(enc_i(OP_SB,    5'd1, 5'd2, 16'hFFFF));
        // signed compares
        instr_stream.push_back(enc_r(FN_SLT,   5'd2, 5'd3, 5'd8, 5'd0));
        instr_stream.push_back(enc_i(OP_SLTI,  5'd3, 5'd9, 16'hFFFF));
        instr_stream.push_back(enc_r(FN_ADD,   5'd2, 5'd2, 5'd10, 5'd0));
        instr_stream.push_back(enc_r(FN_ADDU,  5'd1, 5'd3, 5'd11, 5'd0));
        instr_stream.push_back(enc_r(FN_SUB,   5'd0, 5'd2, 5'd12, 5'd0));
        instr_stream.push_back(enc_r(FN_AND,   5'd2, 5'd3, 5'd13, 5'd0));
        instr_stream.push_back(enc_r(FN_OR,    5'd1, 5'd3, 5'd14, 5'd0));
        instr_stream.push_back(enc_r(FN_XOR,   5'd2, 5'd1, 5'd15, 5'd0));
        instr_stream.push_back(enc_r(FN_SRL,   5'd0, 5'd2, 5'd16, 5'd31));
        instr_stream.push_back(enc_r(FN_SLL,   5'd0, 5'd2, 5'd17, 5'd31));
        instr_stream.push_back(enc_i(OP_ANDI,  5'd2, 5'd18, 16'hFFFF));
        instr_stream.push_back(enc_i(OP_XORI,  5'd2, 5'd19, 16'hFFFF));
        // most negative and most positive branch offsets
        instr_stream.push_back(enc_i(OP_BEQ,   5'd0, 5'd0, 16'h8000));
        instr_stream.push_back(enc_i(OP_BNE,   5'd2, 5'd3, 16'h7FFF));
        instr_stream.push_back(enc_j(OP_J,     26'h3FF_FFFF));
        instr_stream.push_back(enc_j(OP_JAL,   26'h000_0000));
        instr_stream.push_back(enc_r(FN_JR,    5'd2, 5'd0, 5'd0, 5'd0));
        instr_stream.push_back(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        // unknown opcode and unknown function, all other bits set
        instr_stream.push_back(32'hFFFF_FFFF);
        instr_stream.push_back(enc_r(6'h3F, 5'd31, 5'd31, 5'd31, 5'd31));
    endtask

    // one random group: mostly well-formed code around base pointers held in
    // $28..$30 so that loads find earlier stores, with raw words as noise
    task automatic add_random_group();
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic [4:0]  base;
        logic [4:0]  sh;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [15:0] imm;
        int          pick;
        rs   = 5'($urandom_range(0, 31));
        rt   = 5'($urandom_range(0, 31));
        sh   = 5'($urandom_range(0, 31));
        imm  = 16'($urandom_range(0, 16'hFFFF));
        dest = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 27));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // base pointer: mostly the bottom of the window, sometimes its top edge or anywhere in it
            base = 5'($urandom_range(28, 30));
            case ($urandom_range(0, 7))
                0:       imm = 16'($urandom_range(MEM_BYTES - 8, MEM_BYTES - 1));
                1:       imm = 16'($urandom_range(0, MEM_BYTES - 1));
                default: imm = 16'($urandom_range(0, 255));
            endcase
            instr_stream.push_back(enc_i(OP_LUI,   5'd0, base, DATA_BASE[31:16]));
            instr_stream.push_back(enc_i(OP_ADDIU, base, base, imm));
        end else if (pick < 42) begin
            case ($urandom_range(0, 5))
                0:       op = OP_LW;
                1:       op = OP_LH;
                2:       op = OP_LB;
                3:       op = OP_SW;
                4:       op = OP_SH;
                default: op = OP_SB;
            endcase
            base = ($urandom_range(0, 7) == 0) ? rs : 5'($urandom_range(28, 30));
            if ($urandom_range(0, 7) != 0)
                imm = 16'($urandom_range(0, 127)) - 16'd64;
            if (op == OP_LW || op == OP_LH || op == OP_LB)
                rt = dest;
            instr_stream.push_back(enc_i(op, base, rt, imm));
        end else if (pick < 70) begin
            case ($urandom_range(0, 8))
                0:       fn = FN_ADD;
                1:       fn = FN_ADDU;
                2:       fn = FN_SUB;
                3:       fn = FN_AND;
                4:       fn = FN_OR;
                5:       fn = FN_XOR;
                6:       fn = FN_SLT;
                7:       fn = FN_SRL;
                default: fn = FN_SLL;
            endcase
            instr_stream.push_back(enc_r(fn, rs, rt, dest, sh));
        end else if (pick < 88) begin
            case ($urandom_range(0, 6))
                0:       op = OP_ADDI;
                1:       op = OP_ADDIU;
                2:       op = OP_ANDI;
                3:       op = OP_ORI;
                4:       op = OP_XORI;
                5:       op = OP_SLTI;
                default: op = OP_LUI;
            endcase
            instr_stream.push_back(enc_i(op, rs, dest, imm));
        end else if (pick < 96) begin
            case ($urandom_range(0, 5))
                0: instr_stream.push_back(enc_i(OP_BEQ, rs, rt, imm));
                1: instr_stream.push_back(enc_i(OP_BNE, rs, rt, imm));
                2: instr_stream.push_back(enc_j(OP_J, 26'($urandom())));
                3: instr_stream.push_back(enc_j(OP_JAL, 26'($urandom())));
                4: instr_stream.push_back(enc_r(FN_JR, rs, rt, dest, sh));
                default: instr_stream.push_back({OP_RTYPE, 20'($urandom()), FN_SYSCALL});
            endcase
        end else begin
            instr_stream.push_back($urandom());
        end
    endtask

    // free-running clock, 8 ns period
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit, counted in clock cycles
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side: alternates between no stall, light, heavy and near
    // continuous stalling, each held for a random stretch of cycles
    initial begin : result_stall
        int stall_mode;
        int span;
        i_stall <= 1'b0;
        forever begin
            stall_mode = $urandom_range(0, 3);
            span       = $urandom_range(16, 128);
            repeat (span) begin
                @(posedge i_clk);
                case (stall_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 15) < 13);
                endcase
            end
        end
    end

    // instruction side: reset, then the whole stream in bursts of transfers
    initial begin : instr_source
        int burst_left;
        int gap_len;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_instr_word <= '0;

        add_directed();
        while (instr_stream.size() < RANDOM_ITEMS + 32)
            add_random_group();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // o_stall stays high while the data memory is being cleared, so the
        // first transfer simply waits on the handshake
        burst_left = 0;
        while (instr_stream.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 256)
                                                         : $urandom_range(1, 24);
                gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap_len > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap_len) @(posedge i_clk);
                end
            end
            // payload held until the transfer completes
            i_valid      <= 1'b1;
            i_instr_word <= instr_stream.pop_front();
            @(posedge i_clk);
            while (o_stall !== 1'b0)
                @(posedge i_clk);
            burst_left--;
        end
        i_valid <= 1'b0;

        // drain: the outstanding count is registered and so lags behind the last transfer
        do
            @(posedge i_clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
